// ----- rtl/core/apq_pkg.sv -----
// ----------------------------------------------------------------------------
// apq_pkg
// Shared types and codes for the array priority queue: command and response
// words, stored entry layout, operation and status codes.
// ----------------------------------------------------------------------------
package apq_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int PRI_W     = 16;
	localparam int DATA_W    = 32;

	localparam logic       FUNC_ENQ = 1'b0;
	localparam logic       FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic                      func;
		logic signed [DATA_W-1:0]  data;
		logic        [PRI_W-1:0]   priority_req;
	} cmd_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  out_data;
		logic        [1:0]         status;
		logic        [3:0]         fill_count;
	} rsp_t;

	typedef struct packed {
		logic signed [DATA_W-1:0]  data;
		logic        [PRI_W-1:0]   pri;
	} entry_t;

	// first: restart the search with this entry; en: compare this entry
	typedef struct packed {
		logic first;
		logic en;
	} scan_ctl_t;

endpackage

// ----- rtl/core/apq_min_unit.sv -----
// ----------------------------------------------------------------------------
// apq_min_unit
// Shared compare unit: tracks the entry with the smallest priority seen in
// one scan, keeping the earliest entry on a tie.
// ----------------------------------------------------------------------------
module apq_min_unit #(
	parameter int IDX_W = 4
) (
	input  logic                  clk,
	input  apq_pkg::scan_ctl_t    ctl,
	input  apq_pkg::entry_t       entry,
	input  logic [IDX_W-1:0]      idx,
	output logic [IDX_W-1:0]      best_idx,
	output logic signed [apq_pkg::DATA_W-1:0] best_data
);

	logic [apq_pkg::PRI_W-1:0]          best_pri_q;
	logic [IDX_W-1:0]                   best_idx_q;
	logic signed [apq_pkg::DATA_W-1:0]  best_data_q;
	logic                               take;

	// strict less-than keeps the earlier entry on equal priority
	assign take = ctl.en & (ctl.first | (entry.pri < best_pri_q));

	always_ff @(posedge clk) begin
		if (take) begin
			best_pri_q  <= entry.pri;
			best_idx_q  <= idx;
			best_data_q <= entry.data;
		end
	end

	assign best_idx  = best_idx_q;
	assign best_data = best_data_q;

endmodule

// ----- rtl/core/array_priority_queue_top.sv -----
// ----------------------------------------------------------------------------
// array_priority_queue_top
// Bounded priority queue of DEPTH entries held in one single-port-read memory.
// An enqueue's response strobes on the next cycle. A dequeue of a queue
// holding N entries reads the entries one per cycle through one shared
// comparator, then picks the winner, then moves each later entry down one
// place, one per cycle; busy stays high for all of it, and the single memory
// read port sets this pace. Full enqueues and empty dequeues answer on the
// next cycle. Each response word is on rsp for exactly one cycle with done
// high; the receiver cannot stall it, so it must take it then.
// ----------------------------------------------------------------------------
module array_priority_queue_top #(
	parameter int DEPTH = apq_pkg::DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  apq_pkg::cmd_t  cmd,
	output logic           done,
	output apq_pkg::rsp_t  rsp
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_PICK  = 2'd2;
	localparam logic [1:0] S_SHIFT = 2'd3;

	logic [1:0]            state_q, state_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [CW-1:0]         scan_q, scan_d;
	logic [CW-1:0]         wr_q, wr_d;
	logic                  done_q, done_d;
	apq_pkg::rsp_t         rsp_q, rsp_d;

	apq_pkg::entry_t       mem [DEPTH];
	apq_pkg::entry_t       rd_q;
	logic                  re, we;
	logic [IW-1:0]         raddr, waddr;
	apq_pkg::entry_t       wdata;

	apq_pkg::scan_ctl_t    ctl;
	logic [CW-1:0]         best_idx;
	logic signed [apq_pkg::DATA_W-1:0] best_data;

	logic                  accept;
	logic [CW-1:0]         scan_nx;
	logic [CW-1:0]         best_nx;
	logic [CW-1:0]         wr_nx2;
	logic [CW+3:0]         fill_ext;

	assign accept  = start & ~busy;
	assign scan_nx = scan_q + 1'b1;
	assign best_nx = best_idx + 1'b1;
	assign wr_nx2  = wr_q + 2'd2;
	assign fill_ext = {4'b0000, cnt_d};

	apq_min_unit #(
		.IDX_W (CW)
	) u_min (
		.clk       (clk),
		.ctl       (ctl),
		.entry     (rd_q),
		.idx       (scan_q),
		.best_idx  (best_idx),
		.best_data (best_data)
	);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		scan_d  = scan_q;
		wr_d    = wr_q;
		done_d  = 1'b0;
		rsp_d   = rsp_q;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		waddr   = '0;
		wdata   = rd_q;
		ctl     = '0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d.out_data = '0;
					done_d         = 1'b1;
					if (cmd.func == apq_pkg::FUNC_ENQ) begin
						if (cnt_q != CW'(DEPTH)) begin
							we          = 1'b1;
							waddr       = cnt_q[IW-1:0];
							wdata.data  = cmd.data;
							wdata.pri   = cmd.priority_req;
							cnt_d       = cnt_q + 1'b1;
							rsp_d.status = apq_pkg::ST_OK;
						end else begin
							rsp_d.status = apq_pkg::ST_FULL;
						end
					end else if (cnt_q == '0) begin
						rsp_d.status = apq_pkg::ST_EMPTY;
					end else begin
						// no response yet: scan first
						done_d  = 1'b0;
						re      = 1'b1;
						raddr   = '0;
						scan_d  = '0;
						state_d = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				ctl.en    = 1'b1;
				ctl.first = (scan_q == '0);
				if (scan_nx == cnt_q) begin
					state_d = S_PICK;
				end else begin
					re     = 1'b1;
					raddr  = scan_nx[IW-1:0];
					scan_d = scan_nx;
				end
			end
			S_PICK: begin
				if (best_nx == cnt_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					cnt_d   = cnt_q - 1'b1;
					rsp_d.out_data = best_data;
					rsp_d.status   = apq_pkg::ST_OK;
				end else begin
					re      = 1'b1;
					raddr   = best_nx[IW-1:0];
					wr_d    = best_idx;
					state_d = S_SHIFT;
				end
			end
			S_SHIFT: begin
				// move the word just read down one place
				we    = 1'b1;
				waddr = wr_q[IW-1:0];
				wdata = rd_q;
				if (wr_nx2 == cnt_q) begin
					state_d = S_IDLE;
					done_d  = 1'b1;
					cnt_d   = cnt_q - 1'b1;
					rsp_d.out_data = best_data;
					rsp_d.status   = apq_pkg::ST_OK;
				end else begin
					re    = 1'b1;
					raddr = wr_nx2[IW-1:0];
					wr_d  = wr_q + 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		rsp_d.fill_count = fill_ext[3:0];
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			done_q  <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		wr_q   <= wr_d;
		rsp_q  <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule
